### rtl/matrix_arbiter_defines.svh
// shared assertion macros for the matrix arbiter
`ifndef MATRIX_ARBITER_DEFINES_SVH
`define MATRIX_ARBITER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MXA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MXA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mxa_pkg.sv
package mxa_pkg;

  // item actions
  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_ARB = 2'd1,
    ACT_UPD = 2'd2
  } action_e;

  localparam int unsigned PORT_FIELD_BITS = 3;

  // position of matrix bit (r,c), r<c, in the packed upper triangle
  function automatic int unsigned pair_idx(int unsigned r, int unsigned c, int unsigned n);
    return r * n - (r * (r + 1)) / 2 + c - r - 1;
  endfunction

endpackage

### rtl/mxa_in_if.sv
interface mxa_in_if #(
  parameter int unsigned ID_BITS  = 16,
  parameter int unsigned TAG_BITS = 16
);
  import mxa_pkg::*;

  logic                                valid;
  logic                                ready;
  logic [1:0]                          action;
  logic [PORT_FIELD_BITS-1:0]          request_port;
  logic [ID_BITS-1:0]                  request_id;
  logic signed [TAG_BITS-1:0]          request_tag;

  modport source (output valid, action, request_port, request_id, request_tag, input ready);
  modport sink   (input valid, action, request_port, request_id, request_tag, output ready);
endinterface

### rtl/mxa_out_if.sv
interface mxa_out_if #(
  parameter int unsigned ID_BITS  = 16,
  parameter int unsigned TAG_BITS = 16
);
  import mxa_pkg::*;

  logic                                valid;
  logic                                ready;
  logic                                grant_valid;
  logic [PORT_FIELD_BITS-1:0]          grant_port;
  logic [ID_BITS-1:0]                  grant_id;
  logic signed [TAG_BITS-1:0]          grant_tag;

  modport source (output valid, grant_valid, grant_port, grant_id, grant_tag, input ready);
  modport sink   (input valid, grant_valid, grant_port, grant_id, grant_tag, output ready);
endinterface

### rtl/mxa_pick.sv
module mxa_pick #(
  parameter int unsigned PORTS = 8
) (
  input  logic [PORTS-1:0]                     pend_i,
  input  logic [PORTS*(PORTS-1)/2-1:0]         prec_i,
  output logic [PORTS-1:0]                     win_oh_o,
  output logic                                 found_o,
  output logic [$clog2(PORTS)-1:0]             win_port_o
);
  import mxa_pkg::*;

  localparam int unsigned PW = $clog2(PORTS);

  // beaten_by[p][q]: port q beats port p
  logic [PORTS-1:0] beaten_by [PORTS];

  for (genvar p = 0; p < PORTS; p++) begin : g_row
    for (genvar q = 0; q < PORTS; q++) begin : g_col
      if (q < p) begin : g_lo
        assign beaten_by[p][q] = prec_i[pair_idx(q, p, PORTS)];
      end else if (q > p) begin : g_hi
        assign beaten_by[p][q] = ~prec_i[pair_idx(p, q, PORTS)];
      end else begin : g_eq
        assign beaten_by[p][q] = 1'b0;
      end
    end
    // pending and not beaten by any other pending port
    assign win_oh_o[p] = pend_i[p] & ~|(pend_i & beaten_by[p]);
  end

  assign found_o = |win_oh_o;

  // lowest winning index
  always_comb begin
    win_port_o = '0;
    for (int p = PORTS - 1; p >= 0; p--) begin
      if (win_oh_o[p]) begin
        win_port_o = PW'(p);
      end
    end
  end

endmodule

### rtl/matrix_arbiter.sv
// matrix arbiter, least recently granted
// an arbitrate item goes through the input register, then the result register
// throughput: one item per cycle unless the output stalls, set by the single-pass mxa_pick
// add and update items give no result and never wait on the output side
// reset: no pending request, last port lowest and higher index wins, no last winner
module matrix_arbiter #(
  parameter int unsigned PORTS    = 8,
  parameter int unsigned ID_BITS  = 16,
  parameter int unsigned TAG_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mxa_in_if.sink    req_i,
  mxa_out_if.source gnt_o
);
  import mxa_pkg::*;
  `include "matrix_arbiter_defines.svh"

  localparam int unsigned PW    = $clog2(PORTS);
  localparam int unsigned NPAIR = PORTS * (PORTS - 1) / 2;

  // input register
  logic                         in_valid_q;
  logic [1:0]                   in_act_q;
  logic [PORT_FIELD_BITS-1:0]   in_port_q;
  logic [ID_BITS-1:0]           in_id_q;
  logic signed [TAG_BITS-1:0]   in_tag_q;

  // arbiter state
  logic [PORTS-1:0]             pend_q, pend_d;
  logic [ID_BITS-1:0]           ids_q [PORTS];
  logic signed [TAG_BITS-1:0]   tags_q [PORTS];
  logic [NPAIR-1:0]             prec_q, prec_d;
  logic                         lw_valid_q, lw_valid_d;
  logic [PW-1:0]                lw_port_q, lw_port_d;

  // result register
  logic                         out_valid_q;
  logic                         gv_q;
  logic [PORT_FIELD_BITS-1:0]   gport_q;
  logic [ID_BITS-1:0]           gid_q;
  logic signed [TAG_BITS-1:0]   gtag_q;

  logic                         out_free, proc, is_add, is_arb, is_upd, add_ok;
  logic [PW-1:0]                add_idx;
  logic [PORTS-1:0]             win_oh;
  logic                         found;
  logic [PW-1:0]                win_port;

  // handshake and item decode
  assign out_free    = ~out_valid_q | gnt_o.ready;
  assign is_add      = (in_act_q == ACT_ADD);
  assign is_arb      = (in_act_q == ACT_ARB);
  assign is_upd      = (in_act_q == ACT_UPD);
  assign proc        = in_valid_q & (~is_arb | out_free);
  assign req_i.ready = ~in_valid_q | proc;
  assign add_ok      = (32'(in_port_q) < PORTS);
  assign add_idx     = PW'(in_port_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      in_act_q  <= req_i.action;
      in_port_q <= req_i.request_port;
      in_id_q   <= req_i.request_id;
      in_tag_q  <= req_i.request_tag;
    end
  end

  // grant decision
  mxa_pick #(.PORTS(PORTS)) u_pick (
    .pend_i     (pend_q),
    .prec_i     (prec_q),
    .win_oh_o   (win_oh),
    .found_o    (found),
    .win_port_o (win_port)
  );

  // pending bits and last winner
  always_comb begin
    pend_d     = pend_q;
    lw_valid_d = lw_valid_q;
    lw_port_d  = lw_port_q;
    if (proc) begin
      case (in_act_q)
        ACT_ADD: begin
          if (add_ok) begin
            pend_d[add_idx] = 1'b1;
          end
        end
        ACT_ARB: begin
          pend_d     = '0;
          lw_valid_d = found;
          lw_port_d  = win_port;
        end
        default: begin
        end
      endcase
    end
  end

  // move the last winner to lowest priority
  always_comb begin
    prec_d = prec_q;
    if (proc && is_upd && lw_valid_q) begin
      for (int unsigned r = 0; r < PORTS; r++) begin
        for (int unsigned c = r + 1; c < PORTS; c++) begin
          if (lw_port_q == PW'(r)) begin
            prec_d[pair_idx(r, c, PORTS)] = 1'b0;
          end else if (lw_port_q == PW'(c)) begin
            prec_d[pair_idx(r, c, PORTS)] = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned r = 0; r < PORTS; r++) begin
        for (int unsigned c = r + 1; c < PORTS; c++) begin
          prec_q[pair_idx(r, c, PORTS)] <= (c == PORTS - 1);
        end
      end
    end else begin
      prec_q <= prec_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= '0;
      lw_valid_q <= 1'b0;
      lw_port_q  <= '0;
    end else begin
      pend_q     <= pend_d;
      lw_valid_q <= lw_valid_d;
      lw_port_q  <= lw_port_d;
    end
  end

  // request id and tag storage
  always_ff @(posedge clk_i) begin
    if (proc && is_add && add_ok) begin
      ids_q[add_idx]  <= in_id_q;
      tags_q[add_idx] <= in_tag_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= proc & is_arb;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && proc && is_arb) begin
      gv_q    <= found;
      gport_q <= PORT_FIELD_BITS'(win_port);
      gid_q   <= found ? ids_q[win_port] : '0;
      gtag_q  <= found ? tags_q[win_port] : '0;
    end
  end

  assign gnt_o.valid       = out_valid_q;
  assign gnt_o.grant_valid = gv_q;
  assign gnt_o.grant_port  = gport_q;
  assign gnt_o.grant_id    = gid_q;
  assign gnt_o.grant_tag   = gtag_q;

  // checks
  `MXA_ASSERT_NOW(a_single_winner, 1'b1, $onehot0(win_oh), "more than one port wins")
  `MXA_ASSERT_NEXT(a_arb_clears, proc && is_arb, pend_q == '0, "requests not cleared")
  `MXA_ASSERT_NOW(a_no_grant_zero, out_valid_q && !gv_q,
                  gport_q == '0 && gid_q == '0 && gtag_q == '0, "empty grant not zero")
  `MXA_ASSERT_NEXT(a_winner_kept, proc && is_arb && found,
                   lw_valid_q && lw_port_q == $past(win_port), "last winner not kept")

endmodule
